// ----- design/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants for the mesh bounding sphere block.
// ----------------------------------------------------------------------------
package mbs_pkg;
  localparam int MaxTriangles = 1024;
  localparam int FracBits     = 12;
  localparam int VtxDepth     = 3 * MaxTriangles;
  localparam int AddrW        = $clog2(VtxDepth);
  localparam int CntW         = $clog2(MaxTriangles + 1);
  localparam int CoordW       = 24;
  localparam int SumW         = 36;
  localparam int DistW        = 52;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
    logic                     last_triangle;
  } mbs_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic        [24:0]       radius;
    logic                     too_many;
  } mbs_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } mbs_vtx_t;
endpackage

// ----- design/mbs_vtx_ram.sv -----
// ----------------------------------------------------------------------------
// mbs_vtx_ram
// Vertex store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbs_vtx_ram
  import mbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrW-1:0]     waddr,
  input  mbs_vtx_t             wdata,
  input  logic [AddrW-1:0]     raddr,
  output mbs_vtx_t             rdata
);
  mbs_vtx_t mem [VtxDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/mbs_div.sv -----
// ----------------------------------------------------------------------------
// mbs_div
// Signed restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module mbs_div
  import mbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SumW-1:0] dividend,
  input  logic [AddrW:0]         divisor,
  output logic                   done,
  output logic signed [SumW-1:0] quotient
);
  logic [SumW-1:0]  q;
  logic [AddrW:0]   rem;
  logic [AddrW:0]   dvs;
  logic             neg;
  logic             busy;
  logic [5:0]       cnt;
  logic [AddrW+1:0] trial;

  assign trial = {rem, q[SumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(SumW - 1);
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SumW-1];
      q   <= dividend[SumW-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= (AddrW+1)'(trial - {1'b0, dvs});
        q   <= {q[SumW-2:0], 1'b1};
      end else begin
        rem <= trial[AddrW:0];
        q   <= {q[SumW-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);
endmodule

// ----- design/mbs_sqrt.sv -----
// ----------------------------------------------------------------------------
// mbs_sqrt
// Radius: isqrt(10201 * d) / 100, bit-serial root, then a reciprocal multiply.
// ----------------------------------------------------------------------------
module mbs_sqrt
  import mbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DistW-1:0] dsq,
  output logic             done,
  output logic [24:0]      radius
);
  localparam int NW = DistW + 14;   // 10201 < 2^14
  localparam int RW = NW / 2;
  // floor(x / 100) == (x * RecipM) >> 37 for every x below 2^32
  localparam logic [31:0] RecipM = 32'd1374389535;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_ROOT = 4'b0100, S_DIV = 4'b1000
  } sq_state_t;

  sq_state_t        state;
  logic [DistW-1:0] d_r;
  logic [NW-1:0]    n;
  logic [RW-1:0]    root;
  logic [RW+1:0]    rem;
  logic [5:0]       cnt;
  logic [RW+1:0]    trial_r;
  logic [RW+1:0]    cmp;
  logic [63:0]      recip_p;
  logic [24:0]      rad_r;

  assign trial_r = {rem[RW-1:0], n[NW-1:NW-2]};
  assign cmp     = {root, 2'b01};
  // root stays below 2^32 since d < 3 * 2^48
  assign recip_p = {32'd0, root[31:0]} * {32'd0, RecipM};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          d_r   <= dsq;
          state <= S_MUL;
        end
        S_MUL: begin
          n     <= NW'(d_r) * NW'(10201);
          root  <= '0;
          rem   <= '0;
          cnt   <= 6'(RW - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          n <= {n[NW-3:0], 2'b00};
          if (trial_r >= cmp) begin
            rem  <= trial_r - cmp;
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= trial_r;
            root <= {root[RW-2:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_DIV;
        end
        S_DIV: begin
          rad_r <= recip_p[61:37];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign radius = rad_r;
endmodule

// ----- design/mesh_bounding_sphere.sv -----
// ----------------------------------------------------------------------------
// mesh_bounding_sphere
// Centroid bounding sphere of a triangle mesh.
// ----------------------------------------------------------------------------
// Triangles arrive one request at a time. Each request is registered when
// taken, then its three vertices go into the vertex RAM one per cycle and
// into running sums, and the input is held off during the writes. A request
// with last_triangle set then starts the final pass: a serial divide of each
// sum by 3N, a walk over all 3N stored vertices at one vertex per cycle
// through the RAM read port plus a pipeline drain, then a bit-serial square
// root and a divide by 100. Triangles past 1024 are dropped and reported
// through too_many. The result is held in an output register until taken;
// the block then clears itself for a new mesh.
// ----------------------------------------------------------------------------
module mesh_bounding_sphere
  import mbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mbs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mbs_out_t out_data
);
  typedef enum logic [6:0] {
    ST_LOAD = 7'b0000001, ST_WR = 7'b0000010, ST_DIV = 7'b0000100,
    ST_SCAN = 7'b0001000, ST_DRAIN = 7'b0010000, ST_ROOT = 7'b0100000,
    ST_OUT = 7'b1000000
  } st_t;

  st_t st;
  logic signed [SumW-1:0]  sum_x, sum_y, sum_z;
  logic [CntW-1:0]         tri_cnt;
  logic                    ovf;
  logic [1:0]              vsel;       // vertex within triangle / div axis
  logic                    is_last;
  mbs_in_t                 req;        // request held during the writes
  logic [AddrW:0]          nv;
  logic [AddrW:0]          raddr_cnt;
  logic signed [CoordW-1:0] cx, cy, cz;
  logic [DistW-1:0]        max_d;

  // RAM write path
  mbs_vtx_t   wv, rv;
  logic       we;
  logic [AddrW-1:0] waddr;
  always_comb begin
    case (vsel)
      2'd0:    wv = '{req.a_x, req.a_y, req.a_z};
      2'd1:    wv = '{req.b_x, req.b_y, req.b_z};
      default: wv = '{req.c_x, req.c_y, req.c_z};
    endcase
  end
  assign we    = (st == ST_WR);
  assign waddr = AddrW'(AddrW'(tri_cnt) * AddrW'(3) + AddrW'(vsel));

  mbs_vtx_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wv),
    .raddr(raddr_cnt[AddrW-1:0]), .rdata(rv)
  );

  // Center divide, one axis at a time
  logic div_start, div_done;
  logic signed [SumW-1:0] div_in, div_q;
  assign div_in = (vsel == 2'd0) ? sum_x : (vsel == 2'd1) ? sum_y : sum_z;
  mbs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in), .divisor(nv),
    .done(div_done), .quotient(div_q)
  );

  // Distance pipeline: read -> diff/square -> sum
  logic              rd_v, sq_v, sm_v;
  logic [49:0]       sqx, sqy, sqz;
  logic [DistW-1:0]  dsum;
  logic signed [CoordW:0] dx, dy, dz;
  assign dx = 25'(rv.x) - 25'(cx);
  assign dy = 25'(rv.y) - 25'(cy);
  assign dz = 25'(rv.z) - 25'(cz);

  always_ff @(posedge clk) begin
    sqx  <= 50'(dx * dx);
    sqy  <= 50'(dy * dy);
    sqz  <= 50'(dz * dz);
    dsum <= DistW'(sqx) + DistW'(sqy) + DistW'(sqz);
  end

  // Root unit
  logic sq_start, sq_done;
  logic [24:0] rad;
  mbs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .dsq(max_d),
    .done(sq_done), .radius(rad)
  );

  assign in_ready  = (st == ST_LOAD);
  assign out_valid = (st == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_LOAD; sum_x <= '0; sum_y <= '0; sum_z <= '0;
      tri_cnt <= '0; ovf <= 1'b0; vsel <= '0; div_start <= 1'b0;
      sq_start <= 1'b0; rd_v <= 1'b0; sq_v <= 1'b0; sm_v <= 1'b0;
      max_d <= '0; raddr_cnt <= '0; is_last <= 1'b0; nv <= '0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      sq_v <= rd_v;
      sm_v <= sq_v;
      rd_v <= 1'b0;
      if (sm_v && dsum > max_d) max_d <= dsum;
      case (st)
        ST_LOAD: if (in_valid) begin
          req     <= in_data;
          is_last <= in_data.last_triangle;
          vsel    <= '0;
          if (tri_cnt < CntW'(MaxTriangles)) st <= ST_WR;
          else begin
            ovf <= 1'b1;
            if (in_data.last_triangle) begin
              nv <= (AddrW+1)'(tri_cnt) * (AddrW+1)'(3);
              div_start <= 1'b1;
              st <= ST_DIV;
            end
          end
        end
        ST_WR: begin
          sum_x <= sum_x + SumW'(wv.x);
          sum_y <= sum_y + SumW'(wv.y);
          sum_z <= sum_z + SumW'(wv.z);
          vsel  <= vsel + 2'd1;
          if (vsel == 2'd2) begin
            tri_cnt <= tri_cnt + 1'b1;
            vsel    <= '0;
            if (is_last) begin
              nv <= (AddrW+1)'(tri_cnt + 1'b1) * (AddrW+1)'(3);
              div_start <= 1'b1;
              st <= ST_DIV;
            end else st <= ST_LOAD;
          end
        end
        ST_DIV: if (div_done) begin
          case (vsel)
            2'd0:    cx <= div_q[CoordW-1:0];
            2'd1:    cy <= div_q[CoordW-1:0];
            default: cz <= div_q[CoordW-1:0];
          endcase
          if (vsel == 2'd2) begin
            vsel <= '0;
            raddr_cnt <= '0;
            max_d <= '0;
            st <= ST_SCAN;
          end else begin
            vsel <= vsel + 2'd1;
            div_start <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (raddr_cnt < nv) begin
            rd_v <= 1'b1;
            raddr_cnt <= raddr_cnt + 1'b1;
          end else st <= ST_DRAIN;
        end
        ST_DRAIN: if (!rd_v && !sq_v && !sm_v) begin
          sq_start <= 1'b1;
          st <= ST_ROOT;
        end
        ST_ROOT: if (sq_done) begin
          out_data <= '{cx, cy, cz, rad, ovf};
          st <= ST_OUT;
        end
        ST_OUT: if (out_ready) begin
          sum_x <= '0; sum_y <= '0; sum_z <= '0;
          tri_cnt <= '0; ovf <= 1'b0; max_d <= '0;
          st <= ST_LOAD;
        end
        default: st <= ST_LOAD;
      endcase
    end
  end
endmodule

// ----- design/mbs_checker.sv -----
// ----------------------------------------------------------------------------
// mbs_checker
// Port-level checks for the mesh bounding sphere block.
// ----------------------------------------------------------------------------
module mbs_checker
  import mbs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input mbs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input mbs_out_t out_data
);
  // No input is taken while a result is pending.
  a_no_ready_with_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_last_no_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_triangle |=> !in_ready)
    else $error("ready right after last triangle");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind mesh_bounding_sphere mbs_checker u_mbs_checker (.*);

// ----- bench/tb_mesh_bounding_sphere.sv -----
// ----------------------------------------------------------------------------
// tb_mesh_bounding_sphere
// Self-checking bench for the centroid bounding sphere block.
// ----------------------------------------------------------------------------
// Triangles are sent as requests over a valid/ready channel. A behavioral
// sphere model tracks the vertex store and the sums, and each mesh end
// (last_triangle) queues one expected sphere. Results are compared field by
// field in order. A directed table covers extreme coordinates and a single
// triangle mesh, then a mesh overruns the store. Random meshes follow,
// mostly small, with an occasional larger one.
// ----------------------------------------------------------------------------
module tb_mesh_bounding_sphere;
  import mbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordMax = 8388607;
  localparam int CoordMin = -8388608;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  mbs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  mbs_out_t out_data;

  mesh_bounding_sphere uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Sphere model state
  logic signed [CoordW-1:0] mdl_x [VtxDepth];
  logic signed [CoordW-1:0] mdl_y [VtxDepth];
  logic signed [CoordW-1:0] mdl_z [VtxDepth];
  longint mdl_sum_x, mdl_sum_y, mdl_sum_z;
  int     mdl_tri_cnt;
  bit     mdl_dropped;

  mbs_out_t pending_spheres[$];
  int  fail_count = 0;
  int  sphere_count = 0;
  int  request_count = 0;
  bit  quiet_tail = 0;
  bit  hold_receiver = 0;

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Applies one accepted triangle; returns 1 and the sphere at a mesh end.
  function automatic bit sphere_model(input mbs_in_t t, output mbs_out_t s);
    longint cx, cy, cz, dx, dy, dz, nv;
    longint unsigned d, best;
    int base;
    s = '0;
    if (mdl_tri_cnt < MaxTriangles) begin
      base = mdl_tri_cnt * 3;
      mdl_x[base] = t.a_x; mdl_y[base] = t.a_y; mdl_z[base] = t.a_z;
      mdl_x[base+1] = t.b_x; mdl_y[base+1] = t.b_y; mdl_z[base+1] = t.b_z;
      mdl_x[base+2] = t.c_x; mdl_y[base+2] = t.c_y; mdl_z[base+2] = t.c_z;
      mdl_sum_x += longint'(t.a_x) + longint'(t.b_x) + longint'(t.c_x);
      mdl_sum_y += longint'(t.a_y) + longint'(t.b_y) + longint'(t.c_y);
      mdl_sum_z += longint'(t.a_z) + longint'(t.b_z) + longint'(t.c_z);
      mdl_tri_cnt++;
    end else begin
      mdl_dropped = 1;
    end
    if (!t.last_triangle) return 0;
    nv = mdl_tri_cnt * 3;
    // SV division truncates toward zero, as the block does
    cx = mdl_sum_x / nv;
    cy = mdl_sum_y / nv;
    cz = mdl_sum_z / nv;
    best = 0;
    for (int v = 0; v < nv; v++) begin
      dx = longint'(mdl_x[v]) - cx;
      dy = longint'(mdl_y[v]) - cy;
      dz = longint'(mdl_z[v]) - cz;
      d = dx*dx + dy*dy + dz*dz;
      if (d > best) best = d;
    end
    s.center_x = cx[23:0];
    s.center_y = cy[23:0];
    s.center_z = cz[23:0];
    s.radius   = 25'(int_sqrt(best * 10201) / 100);
    s.too_many = mdl_dropped;
    mdl_sum_x = 0; mdl_sum_y = 0; mdl_sum_z = 0;
    mdl_tri_cnt = 0; mdl_dropped = 0;
    return 1;
  endfunction

  function automatic void queue_sphere(input mbs_out_t s);
    pending_spheres = {pending_spheres, s};
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stall bursts, one long hold, none in the tail.
  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 0;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_receiver = 0;
      end
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready <= 0;
        for (int i = 0; i < gap; i++) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  // Result checker at the rising edge
  always @(posedge clk) begin
    mbs_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_spheres.size() == 0) begin
        $error("sphere result with none expected: %p", out_data);
        fail_count++;
      end else begin
        want = pending_spheres.pop_front();
        sphere_count++;
        if (out_data.center_x !== want.center_x) begin
          $error("center_x: expected %0d actual %0d", want.center_x, out_data.center_x);
          fail_count++;
        end
        if (out_data.center_y !== want.center_y) begin
          $error("center_y: expected %0d actual %0d", want.center_y, out_data.center_y);
          fail_count++;
        end
        if (out_data.center_z !== want.center_z) begin
          $error("center_z: expected %0d actual %0d", want.center_z, out_data.center_z);
          fail_count++;
        end
        if (out_data.radius !== want.radius) begin
          $error("radius: expected %0d actual %0d", want.radius, out_data.radius);
          fail_count++;
        end
        if (out_data.too_many !== want.too_many) begin
          $error("too_many: expected %0d actual %0d", want.too_many, out_data.too_many);
          fail_count++;
        end
      end
    end
  end

  // Drives one request, models it at acceptance. Optional typed expectation.
  // Called at a falling edge; valid stays up on return so the next request
  // can follow directly, and wait_drained drops it.
  task automatic send_triangle(input mbs_in_t t, input bit has_fixed = 0,
                               input mbs_out_t fixed = '0);
    mbs_out_t s;
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 0;
      for (int i = 0; i < gap; i++) @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sphere_model(t, s)) begin
      if (has_fixed && s !== fixed) begin
        $error("model disagrees with typed sphere: %p vs %p", s, fixed);
        fail_count++;
      end
      queue_sphere(has_fixed ? fixed : s);
    end
    request_count++;
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(input int span);
    int r;
    case ($urandom_range(0, 9))
      0: r = CoordMax;
      1: r = CoordMin;
      2: r = $urandom_range(0, 2*span) - span;
      default: r = $urandom;
    endcase
    return r[23:0];
  endfunction

  function automatic mbs_in_t rand_tri(input bit last, input int span);
    mbs_in_t t;
    t.a_x = rand_coord(span); t.a_y = rand_coord(span); t.a_z = rand_coord(span);
    t.b_x = rand_coord(span); t.b_y = rand_coord(span); t.b_z = rand_coord(span);
    t.c_x = rand_coord(span); t.c_y = rand_coord(span); t.c_z = rand_coord(span);
    t.last_triangle = last;
    return t;
  endfunction

  task automatic send_mesh(input int n);
    for (int i = 0; i < n; i++)
      send_triangle(rand_tri(i == n - 1, $urandom_range(1, 5000)));
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_spheres.size() != 0) @(negedge clk);
  endtask

  typedef struct {
    mbs_in_t  tri_in;
    bit       has_fixed;
    mbs_out_t fixed;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(input mbs_in_t t, input bit has_fixed,
                                  input mbs_out_t fixed);
    stim_row_t row;
    row.tri_in    = t;
    row.has_fixed = has_fixed;
    row.fixed     = fixed;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic mbs_in_t uniform_tri(input int v, input bit last);
    mbs_in_t t;
    logic signed [CoordW-1:0] c;
    c = CoordW'(v);
    t.a_x = c; t.a_y = c; t.a_z = c;
    t.b_x = c; t.b_y = c; t.b_z = c;
    t.c_x = c; t.c_y = c; t.c_z = c;
    t.last_triangle = last;
    return t;
  endfunction

  initial begin
    mbs_in_t t;
    int n;
    mdl_sum_x = 0; mdl_sum_y = 0; mdl_sum_z = 0;
    mdl_tri_cnt = 0; mdl_dropped = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: degenerate triangles give a point sphere at the vertex.
    add_row(uniform_tri(0, 1), 1,
            '{center_x: '0, center_y: '0, center_z: '0,
              radius: '0, too_many: 1'b0});
    add_row(uniform_tri(CoordMax, 1), 1,
            '{center_x: CoordW'(CoordMax), center_y: CoordW'(CoordMax),
              center_z: CoordW'(CoordMax), radius: '0, too_many: 1'b0});
    add_row(uniform_tri(CoordMin, 1), 1,
            '{center_x: CoordW'(CoordMin), center_y: CoordW'(CoordMin),
              center_z: CoordW'(CoordMin), radius: '0, too_many: 1'b0});
    // Opposite extremes across a two-triangle mesh: widest distances
    add_row(uniform_tri(CoordMax, 0), 0, '0);
    add_row(uniform_tri(CoordMin, 1), 0, '0);
    // Mixed signs, negative sums truncate toward zero
    t = uniform_tri(0, 1);
    t.a_x = -24'sd7; t.b_x = 24'sd1; t.c_x = '0;
    t.a_y = CoordW'(CoordMax); t.b_z = CoordW'(CoordMin);
    add_row(t, 0, '0);
    t = uniform_tri(-1, 0);
    add_row(t, 0, '0);
    t.last_triangle = 1; t.c_x = 24'sd2;
    add_row(t, 0, '0);
    foreach (directed_rows[i])
      send_triangle(directed_rows[i].tri_in, directed_rows[i].has_fixed,
                    directed_rows[i].fixed);

    // Full store: 1024 held, then dropped ones, last one dropped too
    send_mesh(MaxTriangles + 3);
    wait_drained();

    // Back-pressure: receiver holds while short meshes keep coming
    hold_receiver = 1;
    for (int m = 0; m < 6; m++) send_mesh($urandom_range(1, 3));
    // Sender pause until every sphere is back
    wait_drained();

    // Random meshes, mostly small
    while (request_count < 1700) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      if (request_count > 1550) quiet_tail = 1;
      send_mesh(n);
    end

    wait_drained();
    repeat (200) @(negedge clk);
    $display("Covered %0d triangle requests and %0d spheres, including full-store drops.",
             request_count, sphere_count);
    if (fail_count == 0 && pending_spheres.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
